### rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BGC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define BGC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BGC_ASSERT(lbl, clk, rstn, prop)
`define BGC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/core/bgc_pkg.sv
// types and constants of the button gesture classifier
`default_nettype none
package bgc_pkg;

  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned THR_BITS   = 24;
  localparam int unsigned CNT_BITS   = 32;
  localparam int unsigned CODE_BITS  = 3;
  localparam int unsigned ADDR_BITS  = 4;
  localparam int unsigned APB_BITS   = 32;
  // stream words padded up to whole bytes
  localparam int unsigned IN_TDATA   = ((TIME_BITS + 1 + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA  = ((CNT_BITS + CODE_BITS + 7) / 8) * 8;

  localparam logic [THR_BITS-1:0] LONG_PRESS_RST   = 24'd1000000;
  localparam logic [THR_BITS-1:0] DOUBLE_CLICK_RST = 24'd400000;

  typedef enum logic [1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_DOUBLE_CLICK = 2'd1,
    REG_EVENTS_EN    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef enum logic [CODE_BITS-1:0] {
    EV_NONE         = 3'd0,
    EV_SINGLE       = 3'd1,
    EV_DOUBLE       = 3'd2,
    EV_LONG_PRESS   = 3'd3,
    EV_LONG_RELEASE = 3'd4
  } event_e;

  typedef struct packed {
    logic [THR_BITS-1:0] long_press_us;
    logic [THR_BITS-1:0] double_click_us;
    logic                events_enable;
  } cfg_t;

  typedef struct packed {
    event_e              event_code;
    logic [CNT_BITS-1:0] events_reported;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/bgc_cfg_regs.sv
// apb register file for thresholds and enable
`default_nettype none
module bgc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bgc_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [bgc_pkg::APB_BITS-1:0]   pwdata,
  output logic      [bgc_pkg::APB_BITS-1:0]   prdata,
  output logic                                pready,
  output bgc_pkg::cfg_t                       cfg_o
);

  bgc_pkg::cfg_t     cfg_q, cfg_d;
  bgc_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx   = bgc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        bgc_pkg::REG_LONG_PRESS:   cfg_d.long_press_us   = pwdata[bgc_pkg::THR_BITS-1:0];
        bgc_pkg::REG_DOUBLE_CLICK: cfg_d.double_click_us = pwdata[bgc_pkg::THR_BITS-1:0];
        bgc_pkg::REG_EVENTS_EN:    cfg_d.events_enable   = pwdata[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_us   <= bgc_pkg::LONG_PRESS_RST;
      cfg_q.double_click_us <= bgc_pkg::DOUBLE_CLICK_RST;
      cfg_q.events_enable   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      bgc_pkg::REG_LONG_PRESS:   prdata = bgc_pkg::APB_BITS'(cfg_q.long_press_us);
      bgc_pkg::REG_DOUBLE_CLICK: prdata = bgc_pkg::APB_BITS'(cfg_q.double_click_us);
      bgc_pkg::REG_EVENTS_EN:    prdata = bgc_pkg::APB_BITS'(cfg_q.events_enable);
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule
`default_nettype wire

### rtl/core/bgc_in_reg.sv
// input register stage for poll samples
`default_nettype none
module bgc_in_reg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_valid_i,
  output logic                                s_ready_o,
  input  wire logic                           level_i,
  input  wire logic [bgc_pkg::TIME_BITS-1:0]  time_i,
  input  wire logic                           advance_i,
  output logic                                valid_o,
  output logic                                level_o,
  output logic      [bgc_pkg::TIME_BITS-1:0]  time_o
);

  logic                          valid_q, valid_d;
  logic                          level_q;
  logic [bgc_pkg::TIME_BITS-1:0] time_q;
  logic                          take;

  // slot frees up when its word moves on this cycle
  assign s_ready_o = !valid_q || advance_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      level_q <= level_i;
      time_q  <= time_i;
    end
  end

  assign valid_o = valid_q;
  assign level_o = level_q;
  assign time_o  = time_q;

endmodule
`default_nettype wire

### rtl/core/bgc_core.sv
// gesture state and single-pass classification of one sample
`default_nettype none
module bgc_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic                           level_i,
  input  wire logic [bgc_pkg::TIME_BITS-1:0]  time_i,
  input  wire bgc_pkg::cfg_t                  cfg_i,
  output bgc_pkg::result_t                    res_o,
  output logic      [bgc_pkg::CNT_BITS-1:0]   total_o
);

  logic                          held_q, held_d;
  logic                          long_rep_q, long_rep_d;
  logic                          pending_q, pending_d;
  logic [bgc_pkg::TIME_BITS-1:0] press_q, press_d;
  logic [bgc_pkg::TIME_BITS-1:0] first_q, first_d;
  logic [bgc_pkg::CNT_BITS-1:0]  total_q, total_d;

  logic                          pressed;
  logic [bgc_pkg::TIME_BITS-1:0] el_press, el_first;
  logic [bgc_pkg::TIME_BITS-1:0] long_thr, dbl_thr;
  logic                          is_long, in_window, first_moved, timed_out;
  bgc_pkg::event_e               ev, ev_out;

  assign pressed  = !level_i;
  assign el_press = time_i - press_q;
  assign el_first = time_i - first_q;
  assign long_thr = bgc_pkg::TIME_BITS'(cfg_i.long_press_us);
  assign dbl_thr  = bgc_pkg::TIME_BITS'(cfg_i.double_click_us);
  assign is_long   = el_press >= long_thr;
  assign in_window = el_first < dbl_thr;

  always_comb begin
    held_d      = held_q;
    long_rep_d  = long_rep_q;
    pending_d   = pending_q;
    press_d     = press_q;
    first_d     = first_q;
    first_moved = 1'b0;
    ev          = bgc_pkg::EV_NONE;
    if (pressed && !held_q) begin
      held_d     = 1'b1;
      press_d    = time_i;
      long_rep_d = 1'b0;
    end else if (!pressed && held_q) begin
      held_d = 1'b0;
      if (is_long) begin
        ev        = bgc_pkg::EV_LONG_RELEASE;
        pending_d = 1'b0;
      end else if (!pending_q || !in_window) begin
        // first click, or a second one too late: restart the window
        pending_d   = 1'b1;
        first_d     = time_i;
        first_moved = 1'b1;
      end else begin
        ev        = bgc_pkg::EV_DOUBLE;
        pending_d = 1'b0;
      end
    end else if (pressed && held_q) begin
      if (!long_rep_q && is_long) begin
        ev         = bgc_pkg::EV_LONG_PRESS;
        long_rep_d = 1'b1;
        pending_d  = 1'b0;
      end
    end
    // elapsed since a freshly set first click is zero
    timed_out = first_moved ? (dbl_thr == '0) : !in_window;
    if (pending_d && !held_d && timed_out) begin
      ev        = bgc_pkg::EV_SINGLE;
      pending_d = 1'b0;
    end
    ev_out  = cfg_i.events_enable ? ev : bgc_pkg::EV_NONE;
    total_d = (ev_out != bgc_pkg::EV_NONE) ? total_q + 1'b1 : total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= 1'b0;
      long_rep_q <= 1'b0;
      pending_q  <= 1'b0;
      press_q    <= '0;
      first_q    <= '0;
      total_q    <= '0;
    end else if (step_i) begin
      held_q     <= held_d;
      long_rep_q <= long_rep_d;
      pending_q  <= pending_d;
      press_q    <= press_d;
      first_q    <= first_d;
      total_q    <= total_d;
    end
  end

  assign res_o.event_code      = ev_out;
  assign res_o.events_reported = total_d;
  assign total_o               = total_q;

endmodule
`default_nettype wire

### rtl/core/bgc_out_reg.sv
// result register driving the output stream
`default_nettype none
module bgc_out_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire bgc_pkg::result_t      res_i,
  output logic                       free_o,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output bgc_pkg::result_t           res_o
);

  logic             valid_q, valid_d;
  bgc_pkg::result_t res_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign res_o     = res_q;

endmodule
`default_nettype wire

### rtl/core/button_gesture_classifier.sv
// top level of the button gesture classifier
// usage:
//   slave stream takes one poll sample per word: raw active-low pin level and
//   a 48-bit microsecond timestamp that wraps. every sample gives exactly one
//   result word on the master stream: a gesture code (none, single click,
//   double click, long press, long release) and the running event count.
//   thresholds and the enable live in three apb registers (0x0 long press us,
//   0x4 double click us, 0x8 events enable); write them only while idle.
//   a word accepted into the input register is classified as it moves on
//   into the result register, which drives the master side.
//   throughput: one word per cycle unless stalled; classification is one pass
//   of compares and 48-bit subtractions between the input and result registers.
//   stall: when the master side is held off, the result register keeps its
//   word, the input register holds one more, and s_axis_tready drops.
//   reset: registers return to 1000000 us, 400000 us and enabled; the gesture
//   state goes to released with no click pending and a zero event count.
`default_nettype none
`include "assert_macros.svh"
module button_gesture_classifier (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] button_level, [48:1] time_us, [55:49] zero
  input  wire logic [bgc_pkg::IN_TDATA-1:0]   s_axis_tdata,
  // master stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [2:0] event_code, [34:3] events_reported, [39:35] zero
  output logic      [bgc_pkg::OUT_TDATA-1:0]  m_axis_tdata,
  // apb configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bgc_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [bgc_pkg::APB_BITS-1:0]   pwdata,
  output logic      [bgc_pkg::APB_BITS-1:0]   prdata,
  output logic                                pready
);

  bgc_pkg::cfg_t                 cfg;
  bgc_pkg::result_t              res, res_out;
  logic                          in_valid, in_level, advance, step;
  logic [bgc_pkg::TIME_BITS-1:0] in_time;
  logic [bgc_pkg::CNT_BITS-1:0]  total;

  bgc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register: takes a new word while the previous one moves on
  bgc_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .level_i   (s_axis_tdata[0]),
    .time_i    (s_axis_tdata[bgc_pkg::TIME_BITS:1]),
    .advance_i (advance),
    .valid_o   (in_valid),
    .level_o   (in_level),
    .time_o    (in_time)
  );

  // gesture state advances only when the result register can take the word
  assign step = in_valid && advance;

  bgc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .level_i (in_level),
    .time_i  (in_time),
    .cfg_i   (cfg),
    .res_o   (res),
    .total_o (total)
  );

  bgc_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step),
    .res_i     (res),
    .free_o    (advance),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res_out)
  );

  assign m_axis_tdata = {
    (bgc_pkg::OUT_TDATA - bgc_pkg::CNT_BITS - bgc_pkg::CODE_BITS)'(0),
    res_out.events_reported,
    res_out.event_code
  };

  // a reported event bumps the count by exactly one, otherwise it holds
  `BGC_ASSERT(a_count_step, clk_i, rst_ni,
    step |-> (res.events_reported == total + ((res.event_code != bgc_pkg::EV_NONE) ? 1 : 0)))
  // nothing is reported while events are disabled
  `BGC_ASSERT_NEVER(a_quiet_when_off, clk_i, rst_ni,
    step && !cfg.events_enable && (res.event_code != bgc_pkg::EV_NONE))
  // a sample blocked by a full result register stays in the input register
  `BGC_ASSERT(a_in_hold, clk_i, rst_ni, (in_valid && !advance) |=> in_valid)

endmodule
`default_nettype wire
